>>> rtl/bdth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdth_pkg
// Shared types, codes and helpers for the button debounce tap/hold block.
// ----------------------------------------------------------------------------
package bdth_pkg;

  localparam int TIME_BITS = 32;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd35;
  localparam logic [15:0] HOLD_RESET     = 16'd1000;

  localparam int CFG_INDEX_BITS = 4;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEBOUNCE = 4'd0,
    REG_HOLD     = 4'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_TAP  = 2'd1,
    EV_HOLD = 2'd2
  } event_t;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [15:0] hold_time;
  } cfg_t;

  // low TIME_BITS bits of the timestamp, zero extended when wider
  function automatic time_t to_time(input logic [31:0] ms);
    logic [63:0] wide;
    wide = {32'd0, ms};
    return wide[TIME_BITS-1:0];
  endfunction

  // zero extended millisecond setting in the time width
  function automatic time_t ms_to_time(input logic [15:0] ms);
    logic [63:0] wide;
    wide = {48'd0, ms};
    return wide[TIME_BITS-1:0];
  endfunction

endpackage

>>> rtl/bdth_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdth_core
// Debounce and tap/hold state; updates once per accepted sample and gives the
// event code of that sample combinationally.
// ----------------------------------------------------------------------------
module bdth_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            level_down,
  input  logic [31:0]     now_ms,
  input  bdth_pkg::cfg_t  cfg,
  output bdth_pkg::event_t ev
);
  import bdth_pkg::*;

  logic  raw_level;
  time_t change_time;
  logic  armed_flag;
  logic  stable_level;
  time_t press_time;
  logic  hold_reported;

  logic  raw_level_next;
  time_t change_time_next;
  logic  armed_flag_next;
  logic  stable_level_next;
  time_t press_time_next;
  logic  hold_reported_next;

  time_t now;
  time_t since_change;
  time_t since_press;
  logic  settled;
  logic  tap_done;

  always_comb begin
    now                = to_time(now_ms);
    raw_level_next     = level_down;
    change_time_next   = (level_down != raw_level) ? now : change_time;
    armed_flag_next    = armed_flag;
    stable_level_next  = stable_level;
    press_time_next    = press_time;
    hold_reported_next = hold_reported;
    tap_done           = 1'b0;
    ev                 = EV_NONE;
    since_change       = now - change_time_next;
    settled            = since_change >= ms_to_time(cfg.debounce_time);
    if (settled) begin
      if (!armed_flag) begin
        if (!level_down) begin
          armed_flag_next = 1'b1;
        end
      end else begin
        if (stable_level != level_down) begin
          stable_level_next = level_down;
          if (level_down) begin
            press_time_next    = now;
            hold_reported_next = 1'b0;
          end else if (!hold_reported) begin
            ev       = EV_TAP;
            tap_done = 1'b1;
          end
        end
      end
    end
    since_press = now - press_time_next;
    if (settled && armed_flag && !tap_done && stable_level_next && !hold_reported_next &&
        since_press >= ms_to_time(cfg.hold_time)) begin
      hold_reported_next = 1'b1;
      ev                 = EV_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level     <= 1'b0;
      change_time   <= '0;
      armed_flag    <= 1'b0;
      stable_level  <= 1'b0;
      press_time    <= '0;
      hold_reported <= 1'b0;
    end else if (step) begin
      raw_level     <= raw_level_next;
      change_time   <= change_time_next;
      armed_flag    <= armed_flag_next;
      stable_level  <= stable_level_next;
      press_time    <= press_time_next;
      hold_reported <= hold_reported_next;
    end
  end

endmodule

>>> rtl/button_debounce_tap_hold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_tap_hold
// Button debouncer with tap and long-press (hold) events.
//
// Input channel: in_valid/in_ready with level_down (raw level, 1 pressed)
// and now_ms (millisecond timestamp, wraps). Output channel:
// out_valid/out_ready with event_res (0 none, 1 tap, 2 hold), exactly one
// result beat per input beat, in order.
// Configuration: cfg_we/cfg_index/cfg_data; index 0 debounce_time,
// index 1 hold_time, other indexes ignored. Write only while idle.
// Each event is registered into the result register, or the skid stage on a
// stall. Throughput: one beat per cycle while in_ready is high; the state
// update is one pass of subtract/compare logic ahead of the result register.
// A stalled receiver is absorbed by a one-entry skid stage behind the result
// register, so in_ready stays high with one result waiting and drops only
// when both are full.
// Reset: clears the debounce state, loads debounce 35 ms and hold 1000 ms,
// empties the output stages. The block starts unarmed until a settled
// release is seen.
// ----------------------------------------------------------------------------
module button_debounce_tap_hold (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        level_down,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_res,
  input  logic        cfg_we,
  input  logic [bdth_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import bdth_pkg::*;

  cfg_t   cfg;
  event_t ev;
  logic   accept;

  logic   main_valid;
  event_t main_ev;
  logic   skid_valid;
  event_t skid_ev;

  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;
  assign out_valid = main_valid;
  assign event_res = main_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time <= DEBOUNCE_RESET;
      cfg.hold_time     <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg.debounce_time <= cfg_data;
        REG_HOLD:     cfg.hold_time     <= cfg_data;
        default: ;
      endcase
    end
  end

  bdth_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .level_down (level_down),
    .now_ms     (now_ms),
    .cfg        (cfg),
    .ev         (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
      main_ev    <= EV_NONE;
      skid_ev    <= EV_NONE;
    end else if (out_ready || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        main_ev    <= skid_ev;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= accept;
        main_ev    <= ev;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
      skid_ev    <= ev;
    end
  end

  // skid only fills behind a waiting result
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid stage full with empty result register");

  a_no_code_three: assert property (@(posedge clk) disable iff (rst)
    main_valid |-> (event_res != 2'd3))
    else $error("invalid event code");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && (out_ready || !main_valid)) |=> main_valid)
    else $error("accepted beat produced no result");

  a_stall_keeps_beats: assert property (@(posedge clk) disable iff (rst)
    (main_valid && !out_ready && accept) |=> (skid_valid && main_valid))
    else $error("beat lost under output stall");

endmodule

>>> dv/tb_button_debounce_tap_hold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_tap_hold
// Self-checking bench for the button debouncer with tap and hold events.
// A class tracks the debounce, arming and press state to predict the event
// for every accepted sample and compares it against each result beat. A
// short directed run covers power-on press, bounce, tap, hold, timestamp
// wrap and zero settings, then random press gestures with bounce and noise
// run under several register settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_button_debounce_tap_hold;
  import bdth_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  class tap_hold_scoreboard;
    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
    logic        raw_down;
    logic        stable_down;
    logic        armed;
    logic        hold_seen;
    time_t       change_at;
    time_t       press_at;
    event_t      events_due[$];
    int          errors;

    function new();
      debounce_ms = DEBOUNCE_RESET;
      hold_ms     = HOLD_RESET;
      raw_down    = 1'b0;
      stable_down = 1'b0;
      armed       = 1'b0;
      hold_seen   = 1'b0;
      change_at   = '0;
      press_at    = '0;
      errors      = 0;
    endfunction

    function void note_config(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
      case (idx)
        REG_DEBOUNCE: debounce_ms = val;
        REG_HOLD:     hold_ms = val;
        default: ;
      endcase
    endfunction

    // work out the event for one accepted sample
    function void take_sample(logic down, logic [31:0] ms);
      time_t  t;
      event_t ev;
      logic   tapped;
      t = ms;
      ev = EV_NONE;
      tapped = 1'b0;
      if (down != raw_down) begin
        raw_down = down;
        change_at = t;
      end
      if (time_t'(t - change_at) >= time_t'(debounce_ms)) begin
        if (!armed) begin
          if (!down) armed = 1'b1;
        end else begin
          if (stable_down != raw_down) begin
            stable_down = raw_down;
            if (stable_down) begin
              press_at = t;
              hold_seen = 1'b0;
            end else if (!hold_seen) begin
              ev = EV_TAP;
              tapped = 1'b1;
            end
          end
          if (!tapped && stable_down && !hold_seen &&
              time_t'(t - press_at) >= time_t'(hold_ms)) begin
            hold_seen = 1'b1;
            ev = EV_HOLD;
          end
        end
      end
      events_due = {events_due, ev};
    endfunction

    function void check_event(logic [1:0] got);
      event_t want;
      if (events_due.size() == 0) begin
        $error("event_res: beat with nothing expected, actual %0d", got);
        errors++;
      end else begin
        want = events_due.pop_front();
        if (got !== want) begin
          $error("event_res: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return events_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        level_down = 1'b0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  event_res;
  logic        cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  tap_hold_scoreboard sb = new();

  bit          idle_en = 1'b1;
  int          stall_left = 0;
  int          beats_sent = 0;
  int          cycle_count = 0;
  logic [31:0] clock_ms = '0;
  int          cur_deb = int'(DEBOUNCE_RESET);
  int          cur_hold = int'(HOLD_RESET);

  button_debounce_tap_hold dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .level_down (level_down),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_res  (event_res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (idle_en && stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_event(event_res);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** button_debounce_tap_hold: FAILED **");
    $finish;
  end

  task automatic send_beat(input logic lvl, input logic [31:0] t);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    level_down <= lvl;
    now_ms <= t;
    do @(posedge clk); while (!in_ready);
    sb.take_sample(lvl, t);
    beats_sent++;
    clock_ms = t;
  endtask

  task automatic step(input logic lvl, input int dt);
    send_beat(lvl, clock_ms + dt);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers, then a write to an index with no register behind it
  task automatic set_config(input logic [15:0] deb, input logic [15:0] hold);
    logic [CFG_INDEX_BITS-1:0] stray;
    stray = CFG_INDEX_BITS'($urandom_range(2, (1 << CFG_INDEX_BITS) - 1));
    cfg_we <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= deb;
    @(posedge clk);
    sb.note_config(REG_DEBOUNCE, deb);
    cfg_index <= REG_HOLD;
    cfg_data <= hold;
    @(posedge clk);
    sb.note_config(REG_HOLD, hold);
    cfg_index <= stray;
    cfg_data <= 16'($urandom);
    @(posedge clk);
    sb.note_config(stray, cfg_data);
    cfg_we <= 1'b0;
    cur_deb = int'(deb);
    cur_hold = int'(hold);
  endtask

  // press gestures with bounce on both edges, plus some noise
  task automatic run_gestures(input int count);
    int stop_at;
    logic lvl;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 3) == 0) send_beat(1'($urandom_range(0, 1)), $urandom);
        else step(1'($urandom_range(0, 1)), $urandom_range(0, cur_deb + 1));
      end else begin
        lvl = 1'b1;
        repeat ($urandom_range(0, 3)) begin
          step(lvl, $urandom_range(0, cur_deb / 2));
          lvl = ~lvl;
        end
        repeat ($urandom_range(1, 5)) step(1'b1, $urandom_range(0, (cur_deb + cur_hold) / 2 + 1));
        lvl = 1'b0;
        repeat ($urandom_range(0, 3)) begin
          step(lvl, $urandom_range(0, cur_deb / 2));
          lvl = ~lvl;
        end
        repeat ($urandom_range(1, 4)) step(1'b0, $urandom_range(0, cur_deb + 2));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // power-on press is skipped, a settled release arms
    send_beat(1'b1, 32'd0);
    send_beat(1'b1, 32'd100);
    send_beat(1'b1, 32'd2000);
    send_beat(1'b0, 32'd2010);
    send_beat(1'b0, 32'd2045);
    // bouncy press held long enough for a hold, release gives no tap
    send_beat(1'b1, 32'd2100);
    send_beat(1'b0, 32'd2110);
    send_beat(1'b1, 32'd2120);
    send_beat(1'b1, 32'd2155);
    send_beat(1'b1, 32'd3155);
    send_beat(1'b1, 32'd3500);
    send_beat(1'b0, 32'd3600);
    send_beat(1'b0, 32'd3635);
    // short press gives a tap
    send_beat(1'b1, 32'd4000);
    send_beat(1'b1, 32'd4035);
    send_beat(1'b0, 32'd4100);
    send_beat(1'b0, 32'd4135);
    // timestamp wrap and a step backwards
    send_beat(1'b1, 32'hFFFF_FFF0);
    send_beat(1'b1, 32'h0000_0020);
    send_beat(1'b0, 32'hFFFF_FFFF);
    send_beat(1'b0, 32'h0000_0000);
    wait_idle();

    // zero debounce and zero hold
    set_config(16'd0, 16'd0);
    send_beat(1'b1, 32'd5);
    send_beat(1'b0, 32'd6);
    send_beat(1'b1, 32'd7);
    send_beat(1'b0, 32'd7);
    clock_ms = 32'd7;
    run_gestures(150);
    wait_idle();

    set_config(16'hFFFF, 16'hFFFF);
    clock_ms = $urandom;
    run_gestures(150);
    wait_idle();

    set_config(16'd1, 16'd1);
    clock_ms = 32'hFFFF_FF00;
    run_gestures(150);
    wait_idle();

    set_config(DEBOUNCE_RESET, HOLD_RESET);
    clock_ms = $urandom;
    run_gestures(150);
    wait_idle();

    set_config(16'($urandom_range(0, 60)), 16'($urandom_range(0, 400)));
    clock_ms = $urandom;
    run_gestures(150);
    wait_idle();

    set_config(16'($urandom), 16'($urandom));
    clock_ms = $urandom;
    run_gestures(100);
    wait_idle();

    // final stretch at full rate on both sides
    idle_en = 1'b0;
    set_config(16'($urandom_range(0, 20)), 16'($urandom_range(0, 200)));
    clock_ms = $urandom;
    run_gestures(150);
    wait_idle();

    if (sb.errors == 0) begin
      $display("** button_debounce_tap_hold: PASSED **");
    end else begin
      $display("** button_debounce_tap_hold: FAILED **");
    end
    $finish;
  end

endmodule
